// File: rtl/fdl_pkg.sv
package fdl_pkg;

  // configuration port geometry
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;

  // fixed register widths
  localparam int LenBits  = 13;
  localparam int FracBits = 16;
  localparam int GainBits = 16;

  // fixed-point positions
  localparam int FracShift = 16;
  localparam int GainShift = 12;

  // register indexes
  localparam logic [CfgIdxBits-1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_DELAY_WHOLE = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_DELAY_FRAC  = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_MAKEUP_GAIN = 2'd3;

  // register reset values
  localparam logic [LenBits-1:0]  LINE_LENGTH_RST = 13'd4096;
  localparam logic [LenBits-1:0]  DELAY_WHOLE_RST = 13'd1;
  localparam logic [FracBits-1:0] DELAY_FRAC_RST  = 16'd0;
  localparam logic [GainBits-1:0] MAKEUP_GAIN_RST = 16'd4096;

  // operand selection of the shared multiplier
  typedef enum logic {
    MUL_DIFF_FRAC,
    MUL_BLEND_GAIN
  } mul_sel_e;

endpackage

// File: rtl/fdl_store.sv
module fdl_store #(
  parameter int LINE_DEPTH  = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int AW          = 12
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [SAMPLE_BITS-1:0] wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [SAMPLE_BITS-1:0] rdata_o
);

  logic [SAMPLE_BITS-1:0] mem_q [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fdl_mul.sv
module fdl_mul #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  fdl_pkg::mul_sel_e             sel_i,
  input  logic signed [SAMPLE_BITS:0]   diff_i,
  input  logic [fdl_pkg::FracBits-1:0]  frac_i,
  input  logic signed [SAMPLE_BITS-1:0] blend_i,
  input  logic [fdl_pkg::GainBits-1:0]  gain_i,
  output logic signed [SAMPLE_BITS+17:0] prod_o
);
  import fdl_pkg::*;

  logic signed [SAMPLE_BITS:0]   op_a;
  logic signed [16:0]            op_b;
  logic signed [SAMPLE_BITS+17:0] prod_q;

  // operand selection
  always_comb begin
    case (sel_i)
      MUL_DIFF_FRAC: begin
        op_a = diff_i;
        op_b = $signed({1'b0, frac_i});
      end
      MUL_BLEND_GAIN: begin
        op_a = $signed({blend_i[SAMPLE_BITS-1], blend_i});
        op_b = $signed({1'b0, gain_i});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= op_a * op_b;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/fractional_delay_line_top.sv
// Fractional delay line with linear interpolation and makeup gain.
// Input channel: in_valid_i / in_ready_o carry one signed sample per transaction.
// Output channel: out_valid_o / out_ready_i carry one delayed, interpolated,
// gained and saturated sample per input transaction, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_addr_i
// (0 line length, 1 whole delay, 2 fractional delay, 3 makeup gain) in the
// same cycle; write only while no transaction is in flight.
// Sequence: a small sequencer steps each accepted sample through RD_CUR, RD_OLD,
// MUL_DIFF, BLEND, MUL_GAIN and OUT, and takes a new sample only once the last
// has left OUT. Each sample reads the sample store twice through its single
// read port and uses the one shared multiplier twice (interpolation, then gain).
// Reset: after rst_ni is released the store is cleared one entry per cycle, all
// LINE_DEPTH entries, with in_ready_o low; configuration writes are taken.
// Stall: a finished result waits in the output register; a new input
// transaction is still taken, and its result waits for the output register.
module fractional_delay_line_top #(
  parameter int LINE_DEPTH  = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fdl_pkg::CfgIdxBits-1:0]    cfg_addr_i,
  input  logic [fdl_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o
);
  import fdl_pkg::*;

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LW = $clog2(LINE_DEPTH + 1);
  localparam int PW = SAMPLE_BITS + 18;
  localparam int SUMW = SAMPLE_BITS + 19;

  // sequencer states
  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_RD_CUR   = 3'd2;
  localparam logic [2:0] ST_RD_OLD   = 3'd3;
  localparam logic [2:0] ST_MUL_DIFF = 3'd4;
  localparam logic [2:0] ST_BLEND    = 3'd5;
  localparam logic [2:0] ST_MUL_GAIN = 3'd6;
  localparam logic [2:0] ST_OUT      = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [LenBits-1:0]     line_length_q;
  logic [LenBits-1:0]     delay_whole_q;
  logic [FracBits-1:0]    delay_frac_q;
  logic [GainBits-1:0]    makeup_gain_q;
  logic [AW-1:0]          write_pos_q;
  logic [AW-1:0]          clr_cnt_q;
  logic [AW-1:0]          wr_addr_q;
  logic [AW-1:0]          rd_q;
  logic [AW-1:0]          old_q;
  logic [FracBits-1:0]    frac_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic signed [SAMPLE_BITS-1:0] blend_q;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic                   out_valid_q;

  logic [LW-1:0]          len_eff;
  logic [LenBits-1:0]     whole_raw;
  logic [LW-1:0]          whole_eff;
  logic [FracBits-1:0]    frac_eff;
  logic [LW-1:0]          wp_eff;
  logic [LW:0]            rd_sum;
  logic [LW:0]            rd_wrap;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          old_addr;
  logic [LW-1:0]          wp_inc;

  logic                   in_fire;
  logic                   out_load;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  logic                   mul_en;
  mul_sel_e               mul_sel;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PW-1:0]   prod;
  logic signed [SUMW-1:0] blend_sum;
  logic signed [PW:0]     y_sum;
  logic signed [PW:0]     y_sh;
  logic                   y_fits;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LENGTH_RST;
      delay_whole_q <= DELAY_WHOLE_RST;
      delay_frac_q  <= DELAY_FRAC_RST;
      makeup_gain_q <= MAKEUP_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LINE_LENGTH: line_length_q <= cfg_wdata_i[LenBits-1:0];
        REG_DELAY_WHOLE: delay_whole_q <= cfg_wdata_i[LenBits-1:0];
        REG_DELAY_FRAC:  delay_frac_q  <= cfg_wdata_i[FracBits-1:0];
        REG_MAKEUP_GAIN: makeup_gain_q <= cfg_wdata_i[GainBits-1:0];
        default: ;
      endcase
    end
  end

  // clamped line length and delay
  always_comb begin
    if (line_length_q == '0) begin
      len_eff = LW'(1);
    end else if (32'(line_length_q) > LINE_DEPTH) begin
      len_eff = LW'(LINE_DEPTH);
    end else begin
      len_eff = LW'(line_length_q);
    end
    whole_raw = (delay_whole_q == '0) ? LenBits'(1) : delay_whole_q;
    if (32'(whole_raw) >= 32'(len_eff)) begin
      whole_eff = len_eff;
      frac_eff  = '0;
    end else begin
      whole_eff = LW'(whole_raw);
      frac_eff  = delay_frac_q;
    end
  end

  // read positions for the item being accepted
  always_comb begin
    wp_eff   = (LW'(write_pos_q) >= len_eff) ? '0 : LW'(write_pos_q);
    rd_sum   = {1'b0, wp_eff} + {1'b0, len_eff} - {1'b0, whole_eff};
    rd_wrap  = (rd_sum >= {1'b0, len_eff}) ? (rd_sum - {1'b0, len_eff}) : rd_sum;
    rd_addr  = AW'(rd_wrap);
    old_addr = (rd_addr == '0) ? AW'(len_eff - LW'(1)) : (rd_addr - AW'(1));
    wp_inc   = LW'(wr_addr_q) + LW'(1);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_cnt_q == AW'(LINE_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (in_fire) state_d = ST_RD_CUR;
      ST_RD_CUR:   state_d = ST_RD_OLD;
      ST_RD_OLD:   state_d = ST_MUL_DIFF;
      ST_MUL_DIFF: state_d = ST_BLEND;
      ST_BLEND:    state_d = ST_MUL_GAIN;
      ST_MUL_GAIN: state_d = ST_OUT;
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      write_pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (state_q == ST_MUL_DIFF) begin
        write_pos_q <= (wp_inc >= len_eff) ? '0 : AW'(wp_inc);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q       <= sample_in_i;
      wr_addr_q <= AW'(wp_eff);
      rd_q      <= rd_addr;
      old_q     <= old_addr;
      frac_q    <= frac_eff;
    end
    if (state_q == ST_RD_OLD) begin
      cur_q <= mem_rdata;
    end
    if (state_q == ST_BLEND) begin
      blend_q <= blend_sum[SAMPLE_BITS+FracShift-1:FracShift];
    end
    if (out_load) begin
      out_q <= y_sat;
    end
  end

  // sample store access: clear sweep, new sample write, two reads
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_MUL_DIFF);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : wr_addr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : x_q;
  assign mem_raddr = (state_q == ST_RD_CUR) ? rd_q : old_q;

  fdl_store #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared multiplier: interpolation step, then gain step
  assign diff    = $signed({mem_rdata[SAMPLE_BITS-1], mem_rdata}) -
                   $signed({cur_q[SAMPLE_BITS-1], cur_q});
  assign mul_en  = (state_q == ST_MUL_DIFF) || (state_q == ST_MUL_GAIN);
  assign mul_sel = (state_q == ST_MUL_GAIN) ? MUL_BLEND_GAIN : MUL_DIFF_FRAC;

  fdl_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .sel_i   (mul_sel),
    .diff_i  (diff),
    .frac_i  (frac_q),
    .blend_i (blend_q),
    .gain_i  (makeup_gain_q),
    .prod_o  (prod)
  );

  // rounded blend
  assign blend_sum = (SUMW'(cur_q) <<< FracShift) + SUMW'(prod) +
                     SUMW'(1 << (FracShift - 1));

  // gain rounding and saturation
  assign y_sum  = (PW + 1)'(prod) + (PW + 1)'(1 << (GainShift - 1));
  assign y_sh   = y_sum >>> GainShift;
  assign y_fits = (y_sh[PW:SAMPLE_BITS-1] == '0) || (y_sh[PW:SAMPLE_BITS-1] == '1);
  assign y_sat  = y_fits ? y_sh[SAMPLE_BITS-1:0] :
                  (y_sh[PW] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}) :
                              $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

`ifndef SYNTHESIS
  // an accepted transaction starts the read sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_RD_CUR)
    else $error("accepted transaction did not start the read sequence");

  // read and write positions stay inside the line in use while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) && (state_q != ST_IDLE) |->
      (LW'(rd_q) < len_eff) && (LW'(old_q) < len_eff) && (LW'(wr_addr_q) < len_eff))
    else $error("store position outside the line in use");

  // a new result appears only from the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result presented outside the output step");

  // no result and no input acceptance while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_o && !in_ready_o)
    else $error("channel active during the clearing pass");
`endif

endmodule
